### sv/vfve_pkg.sv
// Package for the voxel face vertex emitter: constants, the queued face record type
// and the small decode functions shared by the front and back parts.
// No dependencies.
`timescale 1ns / 1ps

package vfve_pkg;

    // Atlas and coordinate configuration.
    localparam int ATLAS_TILES_PER_ROW = 16;
    localparam int COORD_WIDTH         = 16;

    // Fixed field widths.
    localparam int IN_COORD_W = 16;
    localparam int POS_W      = 18;
    localparam int TEX_W      = 5;
    localparam int LVL_W      = 4;
    localparam int S_DATA_W   = 88;
    localparam int S_USER_W   = 4;
    localparam int M_DATA_W   = 72;

    // Vertices per visible face and the queue between front and back.
    localparam int VERTS_PER_FACE = 6;
    localparam int VIDX_W         = $clog2(VERTS_PER_FACE);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Bit of the raw coordinate that carries the sign.
    localparam int SIGN_BIT = (COORD_WIDTH <= IN_COORD_W) ? COORD_WIDTH - 1 : IN_COORD_W - 1;

    // Face direction codes.
    typedef enum logic [2:0] {
        FACE_POS_Z = 3'd0,
        FACE_NEG_Z = 3'd1,
        FACE_NEG_X = 3'd2,
        FACE_POS_X = 3'd3,
        FACE_POS_Y = 3'd4,
        FACE_NEG_Y = 3'd5
    } face_dir_t;

    // One classified face as held in the queue.
    typedef struct packed {
        logic [POS_W-1:0] base_x;
        logic [POS_W-1:0] base_y;
        logic [POS_W-1:0] base_z;
        logic [2:0]       face;
        logic             flip;
        logic [TEX_W-1:0] tex_u0;
        logic [TEX_W-1:0] tex_v0;
        logic [15:0]      light;
        logic [15:0]      sun;
    } face_rec_t;

    // Twice the coordinate, taken from its low COORD_WIDTH bits, in half-block units.
    function automatic logic [POS_W-1:0] coord_base(input logic [IN_COORD_W-1:0] raw);
        logic [POS_W-1:0] v;
        for (int i = 0; i < POS_W; i++)
        begin
            if (i < COORD_WIDTH && i < IN_COORD_W)
                v[i] = raw[i];
            else if (COORD_WIDTH <= IN_COORD_W)
                v[i] = raw[SIGN_BIT];
            else
                v[i] = 1'b0;
        end
        return {v[POS_W-2:0], 1'b0};
    endfunction

    // Atlas column of the tile, wrapped to the texture width.
    function automatic logic [TEX_W-1:0] tile_u0(input logic [7:0] tile);
        logic [7:0] col;
        col = 8'(tile % ATLAS_TILES_PER_ROW);
        return col[TEX_W-1:0];
    endfunction

    // Flipped atlas row of the tile, wrapped to the texture width.
    function automatic logic [TEX_W-1:0] tile_v0(input logic [7:0] tile);
        logic [7:0] row;
        int         t;
        row = 8'(tile / ATLAS_TILES_PER_ROW);
        t   = ATLAS_TILES_PER_ROW - 1 - int'(row);
        return t[TEX_W-1:0];
    endfunction

    // Corner taken by each vertex of the two triangles.
    function automatic logic [1:0] vert_corner(input logic flip, input logic [VIDX_W-1:0] vidx);
        logic [1:0] c;
        if (flip)
        begin
            unique case (vidx)
                3'd0:    c = 2'd0;
                3'd1:    c = 2'd1;
                3'd2:    c = 2'd3;
                3'd3:    c = 2'd3;
                3'd4:    c = 2'd1;
                3'd5:    c = 2'd2;
                default: c = 2'd0;
            endcase
        end
        else
        begin
            unique case (vidx)
                3'd0:    c = 2'd0;
                3'd1:    c = 2'd1;
                3'd2:    c = 2'd2;
                3'd3:    c = 2'd0;
                3'd4:    c = 2'd2;
                3'd5:    c = 2'd3;
                default: c = 2'd0;
            endcase
        end
        return c;
    endfunction

    // Corner offset signs {x, y, z}: a set bit means plus one half-unit, clear minus one.
    function automatic logic [2:0] corner_sign(input logic [2:0] face, input logic [1:0] c);
        logic [11:0] row;
        unique case (face)
            FACE_POS_Z: row = {3'b101, 3'b111, 3'b011, 3'b001};
            FACE_NEG_Z: row = {3'b000, 3'b010, 3'b110, 3'b100};
            FACE_NEG_X: row = {3'b001, 3'b011, 3'b010, 3'b000};
            FACE_POS_X: row = {3'b100, 3'b110, 3'b111, 3'b101};
            FACE_POS_Y: row = {3'b111, 3'b110, 3'b010, 3'b011};
            FACE_NEG_Y: row = {3'b100, 3'b101, 3'b001, 3'b000};
            default:    row = '0;
        endcase
        return row[c*3 +: 3];
    endfunction

    // Plus or minus one half-unit as an 18-bit addend.
    function automatic logic [POS_W-1:0] half_step(input logic plus);
        return plus ? POS_W'(1) : {POS_W{1'b1}};
    endfunction

endpackage

### sv/voxel_face_vertex_emitter_top.sv
// Top level of the voxel face vertex emitter: front classifier, face queue and
// vertex sequencer. Depends on vfve_pkg, vfve_front, vfve_queue and vfve_back.
//
//   Channel   Dir   Word                                           Sideband
//   s_axis    in    one cube face (position, tile, corner levels)   tuser: face_dir, visible
//   m_axis    out   one vertex (position, atlas u/v, levels)        tlast: sixth vertex
//
// A visible face leaves as six vertex words in order; the vertex sequencer emits one
// vertex a cycle while the output is not stalled, and faces queue up behind it.
// Hidden faces and undefined directions are taken and give nothing.
// The first vertex of a face passes through the face queue and then the output register.
// The input is ready while the two-entry face queue has room; output stalls back up
// into that queue. Reset is asynchronous and empties queue and output register.
`timescale 1ns / 1ps

module voxel_face_vertex_emitter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // block_x[15:0], block_y[31:16], block_z[47:32], tile_index[55:48],
    // corner_light[71:56], corner_sun[87:72]
    input  logic [vfve_pkg::S_DATA_W-1:0] s_axis_tdata,
    // face_dir[2:0], visible[3]
    input  logic [vfve_pkg::S_USER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pos_x[17:0], pos_y[35:18], pos_z[53:36], tex_u[58:54], tex_v[63:59],
    // vert_light[67:64], vert_sun[71:68]
    output logic [vfve_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    logic                push;
    logic                queue_full;
    logic                pop;
    logic                head_valid;
    vfve_pkg::face_rec_t push_rec;
    vfve_pkg::face_rec_t head_rec;

    // Classifier.
    vfve_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_rec      (push_rec)
    );

    // Face queue.
    vfve_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Vertex sequencer.
    vfve_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_rec      (head_rec),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### sv/vfve_front.sv
// Front part of the voxel face vertex emitter: takes face words, drops hidden or
// undefined faces and builds the record that the back part expands.
// Depends on vfve_pkg.
`timescale 1ns / 1ps

module vfve_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // block_x[15:0], block_y[31:16], block_z[47:32], tile_index[55:48],
    // corner_light[71:56], corner_sun[87:72]
    input  logic [vfve_pkg::S_DATA_W-1:0] s_axis_tdata,
    // face_dir[2:0], visible[3]
    input  logic [vfve_pkg::S_USER_W-1:0] s_axis_tuser,
    input  logic                          queue_full,
    output logic                          push,
    output vfve_pkg::face_rec_t           push_rec
);

    logic [2:0]  face;
    logic        shown;
    logic [7:0]  tile;
    logic [15:0] light;
    logic [4:0]  sum_02;
    logic [4:0]  sum_13;

    // Field split.
    assign face  = s_axis_tuser[2:0];
    assign tile  = s_axis_tdata[55:48];
    assign light = s_axis_tdata[71:56];

    // A word is taken whenever the queue has room; hidden faces simply vanish.
    assign s_axis_tready = !queue_full;
    assign shown         = s_axis_tuser[3] && (face <= 3'(vfve_pkg::FACE_NEG_Y));
    assign push          = s_axis_tvalid && !queue_full && shown;

    // Ambient-occlusion diagonal choice; a tie keeps the plain split.
    assign sum_02 = {1'b0, light[3:0]} + {1'b0, light[11:8]};
    assign sum_13 = {1'b0, light[7:4]} + {1'b0, light[15:12]};

    // Record built for the queue.
    always_comb
    begin
        push_rec.base_x = vfve_pkg::coord_base(s_axis_tdata[15:0]);
        push_rec.base_y = vfve_pkg::coord_base(s_axis_tdata[31:16]);
        push_rec.base_z = vfve_pkg::coord_base(s_axis_tdata[47:32]);
        push_rec.face   = face;
        push_rec.flip   = (sum_02 > sum_13);
        push_rec.tex_u0 = vfve_pkg::tile_u0(tile);
        push_rec.tex_v0 = vfve_pkg::tile_v0(tile);
        push_rec.light  = light;
        push_rec.sun    = s_axis_tdata[87:72];
    end

endmodule

### sv/vfve_queue.sv
// Short queue of face records between the front and back parts of the emitter.
// Depends on vfve_pkg.
`timescale 1ns / 1ps

module vfve_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vfve_pkg::face_rec_t push_rec,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output vfve_pkg::face_rec_t head_rec
);

    vfve_pkg::face_rec_t               slot_reg [vfve_pkg::QUEUE_DEPTH];
    logic [vfve_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [vfve_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [vfve_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [vfve_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [vfve_pkg::QCNT_W-1:0]       count_reg;
    logic [vfve_pkg::QCNT_W-1:0]       count_next;

    assign full       = (count_reg == vfve_pkg::QCNT_W'(vfve_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vfve_pkg::QPTR_W'(vfve_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vfve_pkg::QPTR_W'(vfve_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

### sv/vfve_back.sv
// Back part of the voxel face vertex emitter: walks the six vertices of the face at
// the head of the queue, one a cycle unless the output stalls, into a registered output word.
// Depends on vfve_pkg.
`timescale 1ns / 1ps

module vfve_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  vfve_pkg::face_rec_t           head_rec,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pos_x[17:0], pos_y[35:18], pos_z[53:36], tex_u[58:54], tex_v[63:59],
    // vert_light[67:64], vert_sun[71:68]
    output logic [vfve_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    logic [vfve_pkg::VIDX_W-1:0] vidx_reg;
    logic [vfve_pkg::VIDX_W-1:0] vidx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [vfve_pkg::M_DATA_W-1:0] out_data_reg;
    logic                        out_last_reg;
    logic                        load;
    logic                        final_vert;
    logic [1:0]                  corner;
    logic [2:0]                  sign;
    logic [vfve_pkg::POS_W-1:0]  pos_x;
    logic [vfve_pkg::POS_W-1:0]  pos_y;
    logic [vfve_pkg::POS_W-1:0]  pos_z;
    logic [vfve_pkg::TEX_W-1:0]  tex_u;
    logic [vfve_pkg::TEX_W-1:0]  tex_v;
    logic [vfve_pkg::LVL_W-1:0]  vert_light;
    logic [vfve_pkg::LVL_W-1:0]  vert_sun;

    // The output register takes a new word whenever it is empty or being drained.
    assign load       = head_valid && (!out_valid_reg || m_axis_tready);
    assign final_vert = (vidx_reg == vfve_pkg::VIDX_W'(vfve_pkg::VERTS_PER_FACE - 1));
    assign pop        = load && final_vert;

    // Vertex of the current step.
    assign corner     = vfve_pkg::vert_corner(head_rec.flip, vidx_reg);
    assign sign       = vfve_pkg::corner_sign(head_rec.face, corner);
    assign pos_x      = head_rec.base_x + vfve_pkg::half_step(sign[2]);
    assign pos_y      = head_rec.base_y + vfve_pkg::half_step(sign[1]);
    assign pos_z      = head_rec.base_z + vfve_pkg::half_step(sign[0]);
    assign tex_u      = head_rec.tex_u0 + vfve_pkg::TEX_W'(corner[1]);
    assign tex_v      = head_rec.tex_v0 + vfve_pkg::TEX_W'(corner[1] ^ corner[0]);
    assign vert_light = head_rec.light[corner*4 +: 4];
    assign vert_sun   = head_rec.sun[corner*4 +: 4];

    // Step counter and output valid.
    always_comb
    begin
        vidx_next      = vidx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            vidx_next      = final_vert ? '0 : vidx_reg + 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vidx_reg      <= vidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {vert_sun, vert_light, tex_v, tex_u, pos_z, pos_y, pos_x};
            out_last_reg <= final_vert;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### sim/tb_voxel_face_vertex_emitter_top.sv
// Self-checking testbench for voxel_face_vertex_emitter_top: drives cube-face words with random
// idling, predicts the six vertex words of each visible face and checks every output word.
// Depends on vfve_pkg and the emitter RTL.
`timescale 1ns / 1ps

module tb_voxel_face_vertex_emitter_top;

    // Codes outside the defined face directions.
    localparam logic [2:0] FACE_UNDEF_6 = 3'd6;
    localparam logic [2:0] FACE_UNDEF_7 = 3'd7;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int FACE_TARGET  = 425;
    localparam int QUIET_FROM   = 380;
    localparam int MID_DRAIN_AT = 200;
    localparam int SETTLE_TAIL  = 20;

    // One cube face as carried by the input channel.
    typedef struct {
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] bz;
        logic [2:0]  dir;
        logic        vis;
        logic [7:0]  tile;
        logic [15:0] light;
        logic [15:0] sun;
    } face_item_t;

    // One vertex as carried by the output channel.
    typedef struct {
        logic [vfve_pkg::POS_W-1:0] px;
        logic [vfve_pkg::POS_W-1:0] py;
        logic [vfve_pkg::POS_W-1:0] pz;
        logic [vfve_pkg::TEX_W-1:0] u;
        logic [vfve_pkg::TEX_W-1:0] v;
        logic [vfve_pkg::LVL_W-1:0] lt;
        logic [vfve_pkg::LVL_W-1:0] sn;
        logic                       last;
    } vertex_t;

    // Expected vertex words of accepted faces, checked in order of arrival.
    class vertex_scoreboard_t;
        vertex_t expected_vertices[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function int outstanding();
            return expected_vertices.size();
        endfunction

        // Corner used by each vertex of the two triangles, for either diagonal.
        function logic [1:0] corner_of(logic flip, int k);
            logic [11:0] seq;
            seq = flip ? {2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd0}
                       : {2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
            return seq[k*2 +: 2];
        endfunction

        // Axes on which a corner lies half a block above the centre; x in bit 0, z in bit 2.
        function logic [2:0] axis_up(logic [2:0] face, logic [1:0] c);
            logic [11:0] corners;
            case (face)
                vfve_pkg::FACE_POS_Z: corners = {3'b101, 3'b111, 3'b110, 3'b100};
                vfve_pkg::FACE_NEG_Z: corners = {3'b000, 3'b010, 3'b011, 3'b001};
                vfve_pkg::FACE_NEG_X: corners = {3'b100, 3'b110, 3'b010, 3'b000};
                vfve_pkg::FACE_POS_X: corners = {3'b001, 3'b011, 3'b111, 3'b101};
                vfve_pkg::FACE_POS_Y: corners = {3'b111, 3'b011, 3'b010, 3'b110};
                default:              corners = {3'b001, 3'b101, 3'b100, 3'b000};
            endcase
            return corners[c*3 +: 3];
        endfunction

        function logic [vfve_pkg::POS_W-1:0] half_units(logic [15:0] coord);
            logic [vfve_pkg::POS_W-1:0] wide;
            wide = {{(vfve_pkg::POS_W-16){coord[15]}}, coord};
            return wide << 1;
        endfunction

        // Work out the six vertices of an accepted face; hidden or undefined faces give none.
        function void predict_face(face_item_t f);
            logic [vfve_pkg::POS_W-1:0] base_x, base_y, base_z;
            logic [4:0]                 diag_a, diag_b;
            logic                       flip;
            logic [1:0]                 c;
            logic [2:0]                 up;
            int                         col, row;
            vertex_t                    vx;
            if (!f.vis || f.dir > vfve_pkg::FACE_NEG_Y)
                return;
            base_x = half_units(f.bx);
            base_y = half_units(f.by);
            base_z = half_units(f.bz);
            col    = int'(f.tile) % vfve_pkg::ATLAS_TILES_PER_ROW;
            row    = int'(f.tile) / vfve_pkg::ATLAS_TILES_PER_ROW;
            // The diagonal flips only when corners 0 and 2 are strictly brighter.
            diag_a = 5'(f.light[3:0]) + 5'(f.light[11:8]);
            diag_b = 5'(f.light[7:4]) + 5'(f.light[15:12]);
            flip   = diag_a > diag_b;
            for (int k = 0; k < vfve_pkg::VERTS_PER_FACE; k++)
            begin
                c     = corner_of(flip, k);
                up    = axis_up(f.dir, c);
                vx.px = base_x + vfve_pkg::POS_W'(up[0] ? 1 : -1);
                vx.py = base_y + vfve_pkg::POS_W'(up[1] ? 1 : -1);
                vx.pz = base_z + vfve_pkg::POS_W'(up[2] ? 1 : -1);
                // Corners 2 and 3 sit at u = 1; corners 1 and 2 at v = 1.
                vx.u    = vfve_pkg::TEX_W'(col + int'(c[1]));
                vx.v    = vfve_pkg::TEX_W'(vfve_pkg::ATLAS_TILES_PER_ROW - 1 - row
                                           + int'(c[1] ^ c[0]));
                vx.lt   = f.light[c*4 +: 4];
                vx.sn   = f.sun[c*4 +: 4];
                vx.last = (k == vfve_pkg::VERTS_PER_FACE - 1);
                expected_vertices.insert(expected_vertices.size(), vx);
            end
        endfunction

        function void compare(string field, logic [vfve_pkg::POS_W-1:0] exp,
                              logic [vfve_pkg::POS_W-1:0] act);
            if (exp !== act)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, exp, act);
                errors++;
            end
        endfunction

        // Check one accepted vertex word against the oldest expectation.
        function void check_vertex(logic [vfve_pkg::M_DATA_W-1:0] data, logic last);
            vertex_t vx;
            if (expected_vertices.size() == 0)
            begin
                $error("vertex word with no vertex expected: 0x%0h", data);
                errors++;
                return;
            end
            vx = expected_vertices.pop_front();
            compare("pos_x", vx.px, data[17:0]);
            compare("pos_y", vx.py, data[35:18]);
            compare("pos_z", vx.pz, data[53:36]);
            compare("tex_u", vfve_pkg::POS_W'(vx.u), vfve_pkg::POS_W'(data[58:54]));
            compare("tex_v", vfve_pkg::POS_W'(vx.v), vfve_pkg::POS_W'(data[63:59]));
            compare("vert_light", vfve_pkg::POS_W'(vx.lt), vfve_pkg::POS_W'(data[67:64]));
            compare("vert_sun", vfve_pkg::POS_W'(vx.sn), vfve_pkg::POS_W'(data[71:68]));
            compare("last", vfve_pkg::POS_W'(vx.last), vfve_pkg::POS_W'(last));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [vfve_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [vfve_pkg::S_USER_W-1:0] s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [vfve_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;

    // Set for the last part of the run, where neither side idles.
    bit quiet = 1'b0;

    vertex_scoreboard_t vertices = new();

    voxel_face_vertex_emitter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit.
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("voxel_face_vertex_emitter_top verification failed");
        $finish;
    end

    // Output side: check each accepted vertex word and stall in random bursts.
    initial
    begin : vertex_sink
        int hold;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                vertices.check_vertex(m_axis_tdata, m_axis_tlast);
            if (hold > 0)
                hold--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 14);
            if (quiet)
                hold = 0;
            m_axis_tready <= (hold == 0);
        end
    end

    function automatic face_item_t make_face(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                                             logic [2:0] dir, logic vis, logic [7:0] tile,
                                             logic [15:0] light, logic [15:0] sun);
        face_item_t f;
        f.bx    = bx;
        f.by    = by;
        f.bz    = bz;
        f.dir   = dir;
        f.vis   = vis;
        f.tile  = tile;
        f.light = light;
        f.sun   = sun;
        return f;
    endfunction

    // Coordinates lean towards the extremes now and then.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic face_item_t random_face();
        face_item_t f;
        logic [3:0] a, b;
        f = make_face(pick_coord(), pick_coord(), pick_coord(), 3'($urandom_range(0, 5)), 1'b1,
                      8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom));
        // Equal diagonal sums now and then, which must not flip.
        if ($urandom_range(0, 7) == 0)
        begin
            a       = 4'($urandom);
            b       = 4'($urandom);
            f.light = {a, b, b, a};
        end
        return f;
    endfunction

    // Faces that the block takes but must turn into nothing.
    function automatic face_item_t random_void_face();
        face_item_t f;
        f = random_face();
        case ($urandom_range(0, 2))
            0:
            begin
                f.vis = 1'b0;
            end
            1:
            begin
                f.dir = $urandom_range(0, 1) ? FACE_UNDEF_7 : FACE_UNDEF_6;
                f.vis = 1'($urandom);
            end
            default:
            begin
                f.dir = 3'($urandom_range(0, 7));
                f.vis = 1'b0;
            end
        endcase
        return f;
    endfunction

    // Present one face word and hold it until the block takes it.
    task automatic send_face(face_item_t f);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {f.sun, f.light, f.tile, f.bz, f.by, f.bx};
        s_axis_tuser  <= {f.vis, f.dir};
        do
            @(posedge clk);
        while (!s_axis_tready);
        vertices.predict_face(f);
        // Random idle burst on the input side.
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Hold off the input until every expected vertex has come out.
    task automatic drain_vertices();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (vertices.outstanding() != 0);
    endtask

    // Stimulus and final verdict.
    initial
    begin : stimulus
        int  sent_faces;
        bit  mid_drained;
        sent_faces  = 0;
        mid_drained = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed faces: coordinate extremes, tile corners, diagonal choice and void faces.
        send_face(make_face(16'h0000, 16'h0000, 16'h0000, vfve_pkg::FACE_POS_Z, 1'b1, 8'h00,
                            16'h0000, 16'h0000));
        send_face(make_face(16'h7FFF, 16'h7FFF, 16'h7FFF, vfve_pkg::FACE_NEG_Z, 1'b1, 8'hFF,
                            16'hFFFF, 16'hFFFF));
        send_face(make_face(16'h8000, 16'h8000, 16'h8000, vfve_pkg::FACE_NEG_X, 1'b1, 8'h0F,
                            16'h0F0F, 16'h1234));
        send_face(make_face(16'hFFFF, 16'h0001, 16'h8000, vfve_pkg::FACE_POS_X, 1'b1, 8'hF0,
                            16'hF0F0, 16'hFEDC));
        send_face(make_face(16'h1234, 16'hFFFE, 16'h7FFF, vfve_pkg::FACE_POS_Y, 1'b1, 8'hA5,
                            16'h0201, 16'h5A5A));
        send_face(make_face(16'h8001, 16'h7FFE, 16'h0000, vfve_pkg::FACE_NEG_Y, 1'b1, 8'h5A,
                            16'h1221, 16'hA5A5));
        send_face(make_face(16'h0010, 16'h0020, 16'h0030, vfve_pkg::FACE_POS_Z, 1'b0, 8'h11,
                            16'h0F0F, 16'hFFFF));
        send_face(make_face(16'h0010, 16'h0020, 16'h0030, FACE_UNDEF_6, 1'b1, 8'h22,
                            16'h0F0F, 16'hFFFF));
        send_face(make_face(16'hFFFF, 16'hFFFF, 16'hFFFF, FACE_UNDEF_7, 1'b1, 8'hFF,
                            16'hFFFF, 16'hFFFF));
        send_face(make_face(16'h0000, 16'h0000, 16'h0000, FACE_UNDEF_7, 1'b0, 8'h00,
                            16'h0000, 16'h0000));
        send_face(make_face(16'h0003, 16'hFFFD, 16'h0100, vfve_pkg::FACE_POS_Z, 1'b1, 8'h37,
                            16'h0112, 16'h8421));
        for (int d = vfve_pkg::FACE_POS_Z; d <= vfve_pkg::FACE_NEG_Y; d++)
        begin
            send_face(make_face(16'h7FFF, 16'h8000, 16'hFFFF, 3'(d), 1'b1, 8'($urandom),
                                16'h0F0F, 16'($urandom)));
            send_face(make_face(16'h8000, 16'h7FFF, 16'h0001, 3'(d), 1'b1, 8'($urandom),
                                16'h7F8E, 16'($urandom)));
        end
        drain_vertices();

        // Random faces, mostly visible, with void faces mixed in.
        while (sent_faces < FACE_TARGET)
        begin
            quiet <= (sent_faces >= QUIET_FROM);
            if (sent_faces == MID_DRAIN_AT && !mid_drained)
            begin
                mid_drained = 1'b1;
                drain_vertices();
            end
            if ($urandom_range(0, 7) == 0)
                send_face(random_void_face());
            else
                send_face(random_face());
            sent_faces++;
        end

        // Wait for the last vertices, then a short tail for stray words.
        drain_vertices();
        repeat (SETTLE_TAIL) @(posedge clk);
        if (vertices.errors == 0 && vertices.outstanding() == 0)
            $display("voxel_face_vertex_emitter_top verification clean");
        else
            $display("voxel_face_vertex_emitter_top verification failed");
        $finish;
    end

endmodule

### voxel_face_vertex_emitter_top.f
sv/vfve_pkg.sv
sv/vfve_front.sv
sv/vfve_queue.sv
sv/vfve_back.sv
sv/voxel_face_vertex_emitter_top.sv
sim/tb_voxel_face_vertex_emitter_top.sv
